@@ hdl/acaa_pkg.sv @@
// ----------------------------------------------------------------------------
// acaa_pkg: shared definitions of the aligned CPU affinity allocator
// Widths, register indexes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package acaa_pkg;

  localparam int MAX_THREADS = 64;
  localparam int OWNER_BITS  = 16;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = 7;
  localparam int MEM_W       = 24;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THREAD_TOTAL = 3'd0,
    CFG_CORE_TOTAL   = 3'd1,
    CFG_SOCKET_TOTAL = 3'd2,
    CFG_MEMORY_TOTAL = 3'd3,
    CFG_SLOT_TOTAL   = 3'd4
  } cfg_idx_t;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_ALIGN,
    ST_SEARCH,
    ST_BIND,
    ST_REL_SCAN,
    ST_REL_DRAIN,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic ready;
    logic accept;
    logic div_load;
    logic div_step;
    logic align_init;
    logic search_step;
    logic bind_step;
    logic rel_issue;
    logic load_out;
  } acaa_cmd_t;

  typedef struct packed {
    logic mode_rel;
    logic bind_cand;
    logic owner_nz;
    logic n_zero;
    logic div_last;
    logic div_sel_sock;
    logic search_end;
    logic search_fit;
    logic bind_last;
    logic rel_last;
  } acaa_sts_t;

endpackage

@@ hdl/aligned_cpu_affinity_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// aligned_cpu_affinity_allocator_unit: per-host CPU, memory and slot allocator
// Allocates counters and binds aligned contiguous CPU runs to an owner tag;
// release returns counters and frees every CPU carrying the tag.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid/in_ready    mode, owner_id, cpus_req, memory_req
//  out_      output     out_valid/out_ready  status, bound, first_cpu, *_left
//  cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item at a time. A release scans one owner entry a cycle over the thread
//  count, up to 64. An allocate that searches runs the two 7-step quotient
//  divisions, then the one-window-a-cycle search over the aligned positions
//  (up to 64, one more when no run fits), then binds its CPUs (up to 64)
//  through the single owner memory write port. Reset is synchronous and needs
//  no clearing pass. A waiting result does not block acceptance of the next
//  item.
// ----------------------------------------------------------------------------
module aligned_cpu_affinity_allocator_unit
  import acaa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [15:0]          in_owner_id,
  input  logic [CNT_W-1:0]     in_cpus_req,
  input  logic [MEM_W-1:0]     in_memory_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_status,
  output logic                 out_bound,
  output logic [5:0]           out_first_cpu,
  output logic [MEM_W-1:0]     out_memory_left,
  output logic [CNT_W-1:0]     out_cpus_left,
  output logic [CNT_W-1:0]     out_slots_left,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MEM_W-1:0]     cfg_data
);

  acaa_cmd_t cmd;
  acaa_sts_t sts;

  acaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  acaa_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_owner_id     (in_owner_id),
    .in_cpus_req     (in_cpus_req),
    .in_memory_req   (in_memory_req),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_status      (out_status),
    .out_bound       (out_bound),
    .out_first_cpu   (out_first_cpu),
    .out_memory_left (out_memory_left),
    .out_cpus_left   (out_cpus_left),
    .out_slots_left  (out_slots_left)
  );

  assign in_ready  = cmd.ready;
  assign cfg_ready = cmd.ready;

  // A refused allocate never reports a bound run.
  a_refused_unbound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_bound && (out_first_cpu == '0))
    else $error("refused allocate reports a bound CPU run");

  // The block is not ready in the cycle after a transfer in.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !cfg_ready)
    else $error("block ready again right after accepting an item");

  // A window fit during the search never belongs to a release item.
  a_bound_only_on_bind : assert property (@(posedge clk) disable iff (!rst_n)
    sts.search_fit && cmd.search_step |=> !sts.bind_cand || !sts.mode_rel)
    else $error("window fit seen on a release item");

endmodule

@@ hdl/acaa_ctrl.sv @@
// ----------------------------------------------------------------------------
// acaa_ctrl: allocator sequencer
// Steps one item through decode, quotient division, aligned search, binding
// or release scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module acaa_ctrl
  import acaa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  input  acaa_sts_t sts,
  output acaa_cmd_t cmd,
  output logic      out_valid
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.ready  = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.mode_rel) begin
          if (sts.owner_nz && !sts.n_zero) begin
            state_nxt = ST_REL_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end else if (sts.bind_cand) begin
          state_nxt = ST_DIV_LOAD;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          // The core quotient comes first, then the socket quotient.
          state_nxt = sts.div_sel_sock ? ST_ALIGN : ST_DIV_LOAD;
        end
      end
      ST_ALIGN: begin
        cmd.align_init = 1'b1;
        state_nxt      = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (sts.search_fit) begin
          state_nxt = ST_BIND;
        end else if (sts.search_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_BIND: begin
        cmd.bind_step = 1'b1;
        if (sts.bind_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_REL_SCAN: begin
        cmd.rel_issue = 1'b1;
        if (sts.rel_last) begin
          state_nxt = ST_REL_DRAIN;
        end
      end
      ST_REL_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ hdl/acaa_dpath.sv @@
// ----------------------------------------------------------------------------
// acaa_dpath: allocator datapath
// Configuration and free counters, the serial quotient divider, the busy map
// with its owner memory, the aligned window search and the result register.
// ----------------------------------------------------------------------------
module acaa_dpath
  import acaa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  acaa_cmd_t            cmd,
  output acaa_sts_t            sts,
  input  logic                 in_mode,
  input  logic [15:0]          in_owner_id,
  input  logic [CNT_W-1:0]     in_cpus_req,
  input  logic [MEM_W-1:0]     in_memory_req,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MEM_W-1:0]     cfg_data,
  output logic                 out_status,
  output logic                 out_bound,
  output logic [5:0]           out_first_cpu,
  output logic [MEM_W-1:0]     out_memory_left,
  output logic [CNT_W-1:0]     out_cpus_left,
  output logic [CNT_W-1:0]     out_slots_left
);

  // Configuration and counters.
  logic [CNT_W-1:0] thread_total_r, core_total_r, socket_total_r, slot_total_r;
  logic [MEM_W-1:0] memory_total_r;
  logic [MEM_W-1:0] free_memory_r, free_memory_nxt;
  logic [CNT_W-1:0] free_cpus_r, free_cpus_nxt;
  logic [CNT_W-1:0] free_slots_r, free_slots_nxt;

  // Item registers.
  logic                  mode_r, refused_r, bind_cand_r, bound_r;
  logic [OWNER_BITS-1:0] owner_r;
  logic [CNT_W-1:0]      cpus_r;
  logic [IDX_W-1:0]      first_r;

  // Divider.
  logic [CNT_W-1:0] div_rem_r, div_quo_r, div_dvs_r, div_dnd_r;
  logic [2:0]       div_cnt_r;
  logic             div_sel_r;
  logic [CNT_W-1:0] tpc_r, tps_r;
  logic [CNT_W:0]   div_trial;
  logic             div_ge;
  logic [CNT_W-1:0] div_q_final, div_units;

  // Search, binding and release.
  logic [MAX_THREADS-1:0] busy_r, win_mask_r, window;
  logic [CNT_W-1:0]       align_r;
  logic [CNT_W:0]         pos_r;
  logic [IDX_W-1:0]       bind_idx_r;
  logic [CNT_W-1:0]       bind_left_r;
  logic [CNT_W-1:0]       rel_idx_r;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic [OWNER_BITS-1:0]  owner_mem [MAX_THREADS];
  logic [OWNER_BITS-1:0]  mem_q_r;
  logic [CNT_W-1:0]       n_cpu;
  logic                   in_range, fits_len, refused_now, cfg_we;
  logic [CNT_W+1:0]       run_end;

  // Output register.
  logic                   out_status_r, out_bound_r;
  logic [5:0]             out_first_r;
  logic [MEM_W-1:0]       out_mem_r;
  logic [CNT_W-1:0]       out_cpus_r, out_slots_r;

  assign n_cpu = (thread_total_r > CNT_W'(MAX_THREADS)) ? CNT_W'(MAX_THREADS) : thread_total_r;
  assign cfg_we = cfg_valid && cmd.ready;
  assign refused_now = (in_mode == MODE_ALLOC) &&
                       ((free_memory_r < in_memory_req) || (free_cpus_r < in_cpus_req));

  // Counter update on accept, then register writes, which also reload counters.
  always_comb begin
    logic [MEM_W:0]   msum;
    logic [CNT_W:0]   csum, ssum;
    msum            = {1'b0, free_memory_r} + {1'b0, in_memory_req};
    csum            = {1'b0, free_cpus_r} + {1'b0, in_cpus_req};
    ssum            = {1'b0, free_slots_r} + {{CNT_W{1'b0}}, 1'b1};
    free_memory_nxt = free_memory_r;
    free_cpus_nxt   = free_cpus_r;
    free_slots_nxt  = free_slots_r;
    if (cmd.accept) begin
      if (in_mode == MODE_RELEASE) begin
        free_memory_nxt = (msum > {1'b0, memory_total_r}) ? memory_total_r : msum[MEM_W-1:0];
        free_cpus_nxt   = (csum > {1'b0, thread_total_r}) ? thread_total_r : csum[CNT_W-1:0];
        free_slots_nxt  = (ssum > {1'b0, slot_total_r}) ? slot_total_r : ssum[CNT_W-1:0];
      end else if (!refused_now) begin
        free_memory_nxt = free_memory_r - in_memory_req;
        free_cpus_nxt   = free_cpus_r - in_cpus_req;
        if (free_slots_r != '0) begin
          free_slots_nxt = free_slots_r - 1'b1;
        end
      end
    end
    if (cfg_we) begin
      case (cfg_index)
        CFG_THREAD_TOTAL: free_cpus_nxt   = cfg_data[CNT_W-1:0];
        CFG_MEMORY_TOTAL: free_memory_nxt = cfg_data;
        CFG_SLOT_TOTAL:   free_slots_nxt  = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thread_total_r <= CNT_W'(64);
      core_total_r   <= CNT_W'(32);
      socket_total_r <= CNT_W'(2);
      memory_total_r <= '0;
      slot_total_r   <= CNT_W'(1);
      free_memory_r  <= '0;
      free_cpus_r    <= CNT_W'(64);
      free_slots_r   <= CNT_W'(1);
    end else begin
      free_memory_r <= free_memory_nxt;
      free_cpus_r   <= free_cpus_nxt;
      free_slots_r  <= free_slots_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_THREAD_TOTAL: thread_total_r <= cfg_data[CNT_W-1:0];
          CFG_CORE_TOTAL:   core_total_r   <= cfg_data[CNT_W-1:0];
          CFG_SOCKET_TOTAL: socket_total_r <= cfg_data[CNT_W-1:0];
          CFG_MEMORY_TOTAL: memory_total_r <= cfg_data;
          CFG_SLOT_TOTAL:   slot_total_r   <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Restoring divider: thread_total over cores or sockets, one bit a cycle.
  assign div_units   = div_sel_r ? socket_total_r : core_total_r;
  assign div_trial   = {div_rem_r, div_dnd_r[CNT_W-1]};
  assign div_ge      = div_trial >= {1'b0, div_dvs_r};
  assign div_q_final = {div_quo_r[CNT_W-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      div_sel_r <= 1'b0;
    end
    if (cmd.div_load) begin
      div_rem_r <= '0;
      div_quo_r <= '0;
      div_dnd_r <= thread_total_r;
      div_cnt_r <= '0;
      // With no units the quotient is the thread count itself.
      div_dvs_r <= (div_units == '0) ? CNT_W'(1) : div_units;
    end
    if (cmd.div_step) begin
      div_rem_r <= div_ge ? CNT_W'(div_trial - {1'b0, div_dvs_r}) : div_trial[CNT_W-1:0];
      div_quo_r <= div_q_final;
      div_dnd_r <= {div_dnd_r[CNT_W-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + 1'b1;
      if (div_cnt_r == 3'(CNT_W - 1)) begin
        if (div_sel_r) begin
          tps_r <= (div_q_final == '0) ? CNT_W'(1) : div_q_final;
        end else begin
          tpc_r <= (div_q_final == '0) ? CNT_W'(1) : div_q_final;
        end
        div_sel_r <= ~div_sel_r;
      end
    end
  end

  // Aligned window search over the busy map.
  assign window   = (busy_r >> pos_r[IDX_W-1:0]) & win_mask_r;
  assign run_end  = {1'b0, pos_r} + {2'b00, cpus_r};
  assign in_range = pos_r < {1'b0, n_cpu};
  assign fits_len = run_end <= {2'b00, n_cpu};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r      <= in_mode;
      owner_r     <= in_owner_id[OWNER_BITS-1:0];
      cpus_r      <= in_cpus_req;
      refused_r   <= refused_now;
      bind_cand_r <= (in_mode == MODE_ALLOC) && !refused_now &&
                     (in_cpus_req > CNT_W'(1)) && (in_owner_id != '0);
      bound_r     <= 1'b0;
      first_r     <= '0;
      rel_idx_r   <= '0;
    end
    if (cmd.align_init) begin
      pos_r <= '0;
      if (cpus_r >= tps_r) begin
        align_r <= tps_r;
      end else if (cpus_r >= tpc_r) begin
        align_r <= tpc_r;
      end else begin
        align_r <= CNT_W'(1);
      end
      if (cpus_r >= CNT_W'(MAX_THREADS)) begin
        win_mask_r <= '1;
      end else begin
        win_mask_r <= ({{(MAX_THREADS-1){1'b0}}, 1'b1} << cpus_r[IDX_W-1:0])
                      - {{(MAX_THREADS-1){1'b0}}, 1'b1};
      end
    end
    if (cmd.search_step) begin
      if (in_range && fits_len && (window == '0)) begin
        bound_r     <= 1'b1;
        first_r     <= pos_r[IDX_W-1:0];
        bind_idx_r  <= pos_r[IDX_W-1:0];
        bind_left_r <= cpus_r;
      end else begin
        pos_r <= pos_r + {1'b0, align_r};
      end
    end
    if (cmd.bind_step) begin
      bind_idx_r  <= bind_idx_r + 1'b1;
      bind_left_r <= bind_left_r - 1'b1;
    end
    if (cmd.rel_issue) begin
      rel_idx_r <= rel_idx_r + 1'b1;
      cmp_idx_r <= rel_idx_r[IDX_W-1:0];
    end
  end

  // Owner memory: one write port for binding, one registered read for release.
  always_ff @(posedge clk) begin
    if (cmd.bind_step) begin
      owner_mem[bind_idx_r] <= owner_r;
    end
    mem_q_r <= owner_mem[rel_idx_r[IDX_W-1:0]];
  end

  // Busy bits act as entry valid bits; a cleared entry reads as free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rel_issue;
      if (cmd.bind_step) begin
        busy_r[bind_idx_r] <= 1'b1;
      end
      if (cmp_vld_r && busy_r[cmp_idx_r] && (mem_q_r == owner_r)) begin
        busy_r[cmp_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= refused_r;
      out_bound_r  <= bound_r;
      out_first_r  <= first_r;
      out_mem_r    <= free_memory_r;
      out_cpus_r   <= free_cpus_r;
      out_slots_r  <= free_slots_r;
    end
  end

  always_comb begin
    sts              = '0;
    sts.mode_rel     = (mode_r == MODE_RELEASE);
    sts.bind_cand    = bind_cand_r;
    sts.owner_nz     = (owner_r != '0);
    sts.n_zero       = (n_cpu == '0);
    sts.div_last     = (div_cnt_r == 3'(CNT_W - 1));
    sts.div_sel_sock = div_sel_r;
    sts.search_end   = !in_range;
    sts.search_fit   = in_range && fits_len && (window == '0);
    sts.bind_last    = (bind_left_r == CNT_W'(1));
    sts.rel_last     = ((rel_idx_r + 1'b1) == n_cpu);
  end

  assign out_status      = out_status_r;
  assign out_bound       = out_bound_r;
  assign out_first_cpu   = out_first_r;
  assign out_memory_left = out_mem_r;
  assign out_cpus_left   = out_cpus_r;
  assign out_slots_left  = out_slots_r;

endmodule

@@ bench/acaa_grant_checker.sv @@
// ----------------------------------------------------------------------------
// acaa_grant_checker: result checker of the aligned CPU affinity allocator
// Watches the request, result and register channels, keeps its own copy of
// the host counters and the owner table, works out the grant of each accepted
// request and compares it field by field with the results in arrival order.
// ----------------------------------------------------------------------------
module acaa_grant_checker
  import acaa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_mode,
  input  logic [15:0]          in_owner_id,
  input  logic [CNT_W-1:0]     in_cpus_req,
  input  logic [MEM_W-1:0]     in_memory_req,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_status,
  input  logic                 out_bound,
  input  logic [5:0]           out_first_cpu,
  input  logic [MEM_W-1:0]     out_memory_left,
  input  logic [CNT_W-1:0]     out_cpus_left,
  input  logic [CNT_W-1:0]     out_slots_left,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MEM_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic             status;
    logic             bound;
    logic [5:0]       first_cpu;
    logic [MEM_W-1:0] memory_left;
    logic [CNT_W-1:0] cpus_left;
    logic [CNT_W-1:0] slots_left;
  } grant_t;

  logic [OWNER_BITS-1:0] cpu_tag [MAX_THREADS];
  int unsigned thread_cnt, core_cnt, socket_cnt, memory_cap, slot_cap;
  int unsigned mem_avail, cpu_avail, slot_avail;
  grant_t      grants_due [$];

  function automatic void clear_host();
    thread_cnt = 64;
    core_cnt   = 32;
    socket_cnt = 2;
    memory_cap = 0;
    slot_cap   = 1;
    mem_avail  = memory_cap;
    cpu_avail  = thread_cnt;
    slot_avail = slot_cap;
    foreach (cpu_tag[k]) cpu_tag[k] = '0;
  endfunction

  // Threads per core or per socket; a zero quotient counts as one thread.
  function automatic int unsigned threads_per(int unsigned units);
    int unsigned q;
    q = (units != 0) ? thread_cnt / units : thread_cnt;
    return (q != 0) ? q : 1;
  endfunction

  function automatic grant_t grant_for(logic mode, logic [OWNER_BITS-1:0] owner,
                                       int unsigned cpus, int unsigned mem);
    grant_t      g;
    int unsigned n, align, i, j, run, first, sum;
    logic        found, blocked;
    g     = '0;
    n     = (thread_cnt < MAX_THREADS) ? thread_cnt : MAX_THREADS;
    found = 1'b0;
    first = 0;
    if (mode == MODE_ALLOC) begin
      if (mem_avail < mem || cpu_avail < cpus) begin
        g.status = 1'b1;
      end else begin
        mem_avail -= mem;
        cpu_avail -= cpus;
        if (slot_avail > 0) slot_avail -= 1;
        if (cpus > 1 && owner != '0) begin
          align = 1;
          if (cpus >= threads_per(socket_cnt)) align = threads_per(socket_cnt);
          else if (cpus >= threads_per(core_cnt)) align = threads_per(core_cnt);
          for (i = 0; i < n && !found; i += align) begin
            run     = 0;
            blocked = 1'b0;
            for (j = 0; j < cpus && i + j < n && !blocked; j++) begin
              if (cpu_tag[i+j] != '0) blocked = 1'b1;
              else run++;
            end
            if (run == cpus) begin
              found = 1'b1;
              first = i;
            end
          end
          if (found) begin
            for (j = 0; j < cpus; j++) cpu_tag[first+j] = owner;
          end
        end
      end
    end else begin
      sum        = cpu_avail + cpus;
      cpu_avail  = (sum > thread_cnt) ? thread_cnt : sum;
      sum        = mem_avail + mem;
      mem_avail  = (sum > memory_cap) ? memory_cap : sum;
      sum        = slot_avail + 1;
      slot_avail = (sum > slot_cap) ? slot_cap : sum;
      if (owner != '0) begin
        for (i = 0; i < n; i++) begin
          if (cpu_tag[i] == owner) cpu_tag[i] = '0;
        end
      end
    end
    g.bound       = found;
    g.first_cpu   = 6'(first);
    g.memory_left = MEM_W'(mem_avail);
    g.cpus_left   = CNT_W'(cpu_avail);
    g.slots_left  = CNT_W'(slot_avail);
    return g;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      clear_host();
      grants_due.delete();
    end else begin
      // Results are checked before the request of the same edge is queued,
      // since a result always belongs to an earlier request.
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          $error("result with no request waiting: status %0d, first_cpu %0d",
                 out_status, out_first_cpu);
          fail_count++;
        end else begin
          want = grants_due.pop_front();
          check_field("status", want.status, out_status);
          check_field("bound", want.bound, out_bound);
          check_field("first_cpu", want.first_cpu, out_first_cpu);
          check_field("memory_left", want.memory_left, out_memory_left);
          check_field("cpus_left", want.cpus_left, out_cpus_left);
          check_field("slots_left", want.slots_left, out_slots_left);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THREAD_TOTAL: begin
            thread_cnt = cfg_data[CNT_W-1:0];
            cpu_avail  = thread_cnt;
          end
          CFG_CORE_TOTAL:   core_cnt   = cfg_data[CNT_W-1:0];
          CFG_SOCKET_TOTAL: socket_cnt = cfg_data[CNT_W-1:0];
          CFG_MEMORY_TOTAL: begin
            memory_cap = cfg_data;
            mem_avail  = memory_cap;
          end
          CFG_SLOT_TOTAL: begin
            slot_cap   = cfg_data[CNT_W-1:0];
            slot_avail = slot_cap;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        grants_due.insert(grants_due.size(),
                          grant_for(in_mode, in_owner_id, in_cpus_req, in_memory_req));
      end
    end
    pending = grants_due.size();
  end

endmodule

@@ bench/aligned_cpu_affinity_allocator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// aligned_cpu_affinity_allocator_unit_tb: testbench of the CPU allocator
// Drives directed and random allocate and release requests over several host
// configurations and idle patterns, including a long result back-pressure
// stretch, and reports the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module aligned_cpu_affinity_allocator_unit_tb;
  import acaa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic             mode;
    logic [15:0]      owner;
    logic [CNT_W-1:0] cpus;
    logic [MEM_W-1:0] mem;
  } request_t;

  typedef struct packed {
    logic [15:0]      owner;
    logic [CNT_W-1:0] cpus;
    logic [MEM_W-1:0] mem;
  } lease_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = 1'b0;
  logic [15:0]          in_owner_id = '0;
  logic [CNT_W-1:0]     in_cpus_req = '0;
  logic [MEM_W-1:0]     in_memory_req = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_status;
  logic                 out_bound;
  logic [5:0]           out_first_cpu;
  logic [MEM_W-1:0]     out_memory_left;
  logic [CNT_W-1:0]     out_cpus_left;
  logic [CNT_W-1:0]     out_slots_left;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MEM_W-1:0]     cfg_data = '0;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          phase_id = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned thr_cfg = 64, core_cfg = 32, sock_cfg = 2, mem_cfg = 0;
  lease_t      leases [$];

  always #5 clk = ~clk;

  aligned_cpu_affinity_allocator_unit u_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_mode, .in_owner_id, .in_cpus_req, .in_memory_req,
    .out_valid, .out_ready, .out_status, .out_bound, .out_first_cpu,
    .out_memory_left, .out_cpus_left, .out_slots_left,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  acaa_grant_checker u_grant_chk (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_mode, .in_owner_id, .in_cpus_req, .in_memory_req,
    .out_valid, .out_ready, .out_status, .out_bound, .out_first_cpu,
    .out_memory_left, .out_cpus_left, .out_slots_left,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // Result side. In the first random phase the receiver holds off for a long
  // stretch so that the block fills up and stops taking requests.
  always @(negedge clk) begin
    if (phase_id == 1 && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic request_t mk_req(logic mode, logic [15:0] owner,
                                      logic [CNT_W-1:0] cpus, logic [MEM_W-1:0] mem);
    request_t r;
    r.mode  = mode;
    r.owner = owner;
    r.cpus  = cpus;
    r.mem   = mem;
    return r;
  endfunction

  function automatic int unsigned span_of(int unsigned units);
    int unsigned q;
    q = (units != 0) ? thr_cfg / units : thr_cfg;
    return (q != 0) ? q : 1;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= r.mode;
    in_owner_id   <= r.owner;
    in_cpus_req   <= r.cpus;
    in_memory_req <= r.mem;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MEM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers are only written once every outstanding result has come back.
  task automatic setup_host(input logic [MEM_W-1:0] thr_data, input int unsigned cores,
                            input int unsigned sockets, input int unsigned mem,
                            input int unsigned slots, input logic spare);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    write_reg(CFG_THREAD_TOTAL, thr_data);
    write_reg(CFG_CORE_TOTAL, MEM_W'(cores));
    write_reg(CFG_SOCKET_TOTAL, MEM_W'(sockets));
    write_reg(CFG_MEMORY_TOTAL, MEM_W'(mem));
    write_reg(CFG_SLOT_TOTAL, MEM_W'(slots));
    if (spare) write_reg(CFG_SPARE_IDX, 24'hFFFFFF);
    cfg_valid <= 1'b0;
    thr_cfg  = thr_data[CNT_W-1:0];
    core_cfg = cores;
    sock_cfg = sockets;
    mem_cfg  = mem;
  endtask

  // Mostly allocate and matching release pairs, with some malformed noise.
  task automatic random_request(output request_t r);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      r.mode  = 1'($urandom_range(1));
      r.owner = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
      r.cpus  = CNT_W'($urandom_range(0, 127));
      r.mem   = 24'($urandom);
    end else if ((pick < 45 || leases.size() >= 40) && leases.size() > 0) begin
      pick    = $urandom_range(0, leases.size() - 1);
      r.mode  = MODE_RELEASE;
      r.owner = leases[pick].owner;
      r.cpus  = leases[pick].cpus;
      r.mem   = leases[pick].mem;
      leases.delete(pick);
      return;
    end else begin
      r.mode  = MODE_ALLOC;
      r.owner = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
                                         : 16'($urandom_range(1, 24));
      case ($urandom_range(3))
        0: r.cpus = CNT_W'($urandom_range(1, 4));
        1: r.cpus = CNT_W'(span_of(core_cfg));
        2: r.cpus = CNT_W'(span_of(sock_cfg));
        default: r.cpus = CNT_W'($urandom_range(1, thr_cfg));
      endcase
      if (mem_cfg == 0) r.mem = '0;
      else if ($urandom_range(3) == 0) r.mem = MEM_W'($urandom_range(0, mem_cfg));
      else r.mem = MEM_W'($urandom_range(0, mem_cfg / 6));
    end
    if (r.mode == MODE_ALLOC) leases.insert(leases.size(), lease_t'({r.owner, r.cpus, r.mem}));
  endtask

  task automatic run_random(input int count);
    request_t r;
    repeat (count) begin
      random_request(r);
      send_request(r);
    end
    // Give back what is still held so the next host starts with a free table.
    while (leases.size() > 0) begin
      lease_t l;
      l = leases.pop_back();
      send_request(mk_req(MODE_RELEASE, l.owner, l.cpus, l.mem));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values of the host counters.
    send_request(mk_req(MODE_ALLOC, 16'd1, 7'd2, 24'd0));
    send_request(mk_req(MODE_RELEASE, 16'd1, 7'd2, 24'd0));

    setup_host(24'd64, 32, 2, 1000, 3, 1'b0);
    send_request(mk_req(MODE_ALLOC, 16'd1, 7'd2, 24'd10));        // core aligned
    send_request(mk_req(MODE_ALLOC, 16'd2, 7'd32, 24'd0));        // socket aligned
    send_request(mk_req(MODE_ALLOC, 16'd3, 7'd1, 24'd5));         // single CPU
    send_request(mk_req(MODE_ALLOC, 16'd0, 7'd4, 24'd5));         // owner zero
    send_request(mk_req(MODE_ALLOC, 16'd4, 7'd0, 24'd0));         // no CPU, no slot
    send_request(mk_req(MODE_ALLOC, 16'd5, 7'd40, 24'd0));        // CPUs short
    send_request(mk_req(MODE_ALLOC, 16'd6, 7'd2, 24'hFFFFFF));    // memory short
    send_request(mk_req(MODE_ALLOC, 16'd7, 7'd3, 24'd0));
    send_request(mk_req(MODE_RELEASE, 16'd2, 7'd32, 24'd0));
    send_request(mk_req(MODE_RELEASE, 16'd0, 7'd127, 24'hFFFFFF)); // saturates
    send_request(mk_req(MODE_RELEASE, 16'd1, 7'd2, 24'd10));
    send_request(mk_req(MODE_RELEASE, 16'd7, 7'd3, 24'd0));
    send_request(mk_req(MODE_ALLOC, 16'hFFFF, 7'd64, 24'd1000));  // whole host
    send_request(mk_req(MODE_ALLOC, 16'h8000, 7'd1, 24'd0));
    send_request(mk_req(MODE_RELEASE, 16'hFFFF, 7'd64, 24'd1000));
    send_request(mk_req(MODE_ALLOC, 16'hAAAA, 7'd33, 24'd999));
    send_request(mk_req(MODE_ALLOC, 16'h5555, 7'd31, 24'd1));     // no run fits
    send_request(mk_req(MODE_RELEASE, 16'hAAAA, 7'd33, 24'd999));
    send_request(mk_req(MODE_RELEASE, 16'h5555, 7'd31, 24'd1));
    send_request(mk_req(MODE_RELEASE, 16'd3, 7'd64, 24'd0));

    setup_host(24'd64, 32, 2, 4096, 64, 1'b0);
    phase_id = 1;
    run_random(400);

    setup_host(24'd16, 8, 2, 24'hFFFFFF, 8, 1'b0);
    phase_id = 2;
    send_idle_pct = 57;
    run_random(300);

    // More threads than the owner table holds, with zero cores and sockets.
    setup_host(24'd96, 0, 0, 100000, 3, 1'b0);
    phase_id = 3;
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    run_random(300);

    setup_host(24'd1, 1, 1, 0, 1, 1'b0);
    phase_id = 4;
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    run_random(150);

    // Upper data bits of a count register are dropped; the spare index is inert.
    setup_host(24'hABCD40, 64, 64, 2048, 2, 1'b1);
    phase_id = 5;
    run_random(250);

    setup_host(24'd48, 100, 5, 65535, 64, 1'b0);
    phase_id = 6;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(200);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/acaa_pkg.sv
hdl/acaa_ctrl.sv
hdl/acaa_dpath.sv
hdl/aligned_cpu_affinity_allocator_unit.sv
bench/acaa_grant_checker.sv
bench/aligned_cpu_affinity_allocator_unit_tb.sv
